FILE: design/cff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cff_pkg: console font file parser shared definitions
// Limits, header constants, result and counter types, and the per-byte step
// of the bitmap and unicode table region.
// ----------------------------------------------------------------------------
package cff_pkg;

	localparam int MAX_FILE_BYTES = 32768;
	localparam int MAX_ROWS       = 32;

	localparam logic [16:0] MAX_FILE_B = 17'(MAX_FILE_BYTES);
	localparam logic [7:0]  MAX_ROWS_B = 8'(MAX_ROWS);

	localparam logic [7:0]  PSF_MAGIC0   = 8'h36;
	localparam logic [7:0]  PSF_MAGIC_HI = 8'h04;
	localparam logic [7:0]  MODE_512   = 8'h01;
	localparam logic [7:0]  MODE_TAB   = 8'h02;
	localparam logic [7:0]  MODE_MAX   = 8'h03;
	localparam logic [15:0] TABLE_SEP  = 16'hFFFF;
	localparam logic [15:0] PSF_HDR    = 16'd4;
	localparam logic [15:0] CPI_LEN    = 16'd9780;
	localparam logic [15:0] CPI_OFFSET = 16'd40;
	localparam logic [7:0]  CPI_HEIGHT = 8'd16;
	localparam logic [9:0]  GLYPHS_256 = 10'd256;
	localparam logic [9:0]  GLYPHS_512 = 10'd512;
	localparam logic [13:0] PAIR_MAX   = 14'h3FFF;
	localparam logic [15:0] POS_MAX    = 16'hFFFF;

	typedef enum logic [1:0] {
		KIND_GLYPH,
		KIND_PAIR,
		KIND_ERROR,
		KIND_DONE
	} cff_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_MODE,
		ERR_PSF_LEN,
		ERR_BARE_SIZE,
		ERR_HEIGHT,
		ERR_TOO_LARGE
	} cff_err_t;

	typedef struct packed {
		cff_kind_t   kind;
		logic [8:0]  glyph_index;
		logic [4:0]  row_index;
		logic [7:0]  bitmap_byte;
		logic [15:0] code_point;
		cff_err_t    error_code;
		logic [5:0]  height_found;
		logic [9:0]  glyphs_found;
		logic [13:0] pairs_found;
		logic        last;
	} cff_res_t;

	typedef struct packed {
		logic [9:0]  glyph_cnt;
		logic [4:0]  row_cnt;
		logic        low_pend;
		logic [7:0]  low_byte;
		logic [13:0] pair_cnt;
		logic [9:0]  table_glyph;
	} cff_ctx_t;

	typedef struct packed {
		logic [5:0]  height;
		logic [9:0]  total;
		logic        has_table;
		logic [15:0] bm_start;
		logic [15:0] bm_end;
	} cff_geom_t;

	typedef struct packed {
		cff_ctx_t ctx;
		logic     hit_v;
		cff_res_t hit;
		logic     done_v;
		cff_res_t done;
	} cff_dstep_t;

	function automatic cff_res_t err_res(cff_err_t code);
		cff_res_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.error_code = code;
		return r;
	endfunction

	// one byte of the data region at position p
	function automatic cff_dstep_t data_step(cff_ctx_t c, cff_geom_t g, logic [15:0] len,
			logic [15:0] p, logic [7:0] b);
		cff_dstep_t r;
		logic [5:0] row_nx;
		logic [15:0] word;
		r = '0;
		r.ctx = c;
		row_nx = {1'b0, c.row_cnt} + 6'd1;
		word = {b, c.low_byte};
		if (p >= g.bm_start && p < g.bm_end) begin
			r.hit_v = 1'b1;
			r.hit.kind = KIND_GLYPH;
			r.hit.glyph_index = c.glyph_cnt[8:0];
			r.hit.row_index = c.row_cnt;
			r.hit.bitmap_byte = b;
			if (row_nx >= g.height) begin
				r.ctx.row_cnt = '0;
				r.ctx.glyph_cnt = c.glyph_cnt + 10'd1;
			end else begin
				r.ctx.row_cnt = row_nx[4:0];
			end
		end else if (g.has_table && p >= g.bm_end) begin
			if (!c.low_pend) begin
				r.ctx.low_pend = 1'b1;
				r.ctx.low_byte = b;
			end else begin
				r.ctx.low_pend = 1'b0;
				r.ctx.low_byte = '0;
				if (c.table_glyph < g.total) begin
					if (word == TABLE_SEP) begin
						r.ctx.table_glyph = c.table_glyph + 10'd1;
					end else begin
						r.hit_v = 1'b1;
						r.hit.kind = KIND_PAIR;
						r.hit.glyph_index = c.table_glyph[8:0];
						r.hit.code_point = word;
						if (c.pair_cnt < PAIR_MAX) begin
							r.ctx.pair_cnt = c.pair_cnt + 14'd1;
						end
					end
				end
			end
		end
		if ({1'b0, p} + 17'd1 == {1'b0, len}) begin
			r.done_v = 1'b1;
			r.done.kind = KIND_DONE;
			r.done.height_found = g.height;
			r.done.glyphs_found = g.total;
			r.done.pairs_found = r.ctx.pair_cnt;
		end
		return r;
	endfunction

endpackage

FILE: design/console_font_file_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_font_file_parser_top: PSF1 / bare console font file parser
// Decodes a font file one byte per item into glyph bytes, unicode pairs,
// errors and a done summary.
// ----------------------------------------------------------------------------
//  channel       | dir | tdata                          | tuser        | tlast
//  s_axis        | in  | file_byte                      | start_of_file| -
//  m_axis        | out | glyph..pairs (see port)        | kind         | last
//  file_length   | in  | write enable + 16-bit data     | -            | -
//
//  One byte per cycle: a byte goes into an input register, is decoded in the
//  next cycle, and its zero to two results enter a 4-entry result queue.
//  A byte is taken while the queue has room for all of its results; a byte
//  that yields two results can hold input while m_axis drains.
//  A stalled m_axis holds the queue; input stops once the queue cannot fit.
//  Reset clears all counters and returns to the header phase; no clearing pass.
// ----------------------------------------------------------------------------
module console_font_file_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
	input  logic [0:0]  s_axis_tuser,   // [0] start_of_file
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [8:0] glyph_index, [13:9] row_index, [21:14] bitmap_byte,
	// [37:22] code_point, [40:38] error_code, [46:41] height_found,
	// [56:47] glyphs_found, [70:57] pairs_found, [71] zero
	output logic [71:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast,
	input  logic        file_length_wr_en,
	input  logic [15:0] file_length_wr_data
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_MODE,
		PH_SIZE,
		PH_DATA,
		PH_IDLE
	} phase_t;

	localparam logic [2:0] Q_DEPTH = 3'd4;

	logic [15:0]       file_length_q;
	logic              valid_s1;
	logic              sof_s1;
	logic [7:0]        byte_s1;
	phase_t            phase_q;
	logic [15:0]       pos_q;
	logic [7:0]        held_q;
	cff_pkg::cff_geom_t geom_q;
	cff_pkg::cff_ctx_t  ctx_q;

	cff_pkg::cff_res_t q_mem_q [4];
	logic [1:0]        wr_ptr_q;
	logic [1:0]        rd_ptr_q;
	logic [2:0]        count_q;

	phase_t            cur_phase;
	logic [15:0]       cur_pos;
	logic [7:0]        cur_held;
	cff_pkg::cff_geom_t cur_geom;
	cff_pkg::cff_ctx_t  cur_ctx;

	phase_t            nxt_phase;
	logic [15:0]       nxt_pos;
	logic [7:0]        nxt_held;
	cff_pkg::cff_geom_t nxt_geom;
	cff_pkg::cff_ctx_t  nxt_ctx;

	logic              act;
	logic              magic;
	logic [7:0]        bare_unit;
	logic [15:0]       bare_offset;
	logic              bare_size_bad;
	cff_pkg::cff_err_t bare_err;
	cff_pkg::cff_geom_t geom_bare;
	logic [16:0]       head;
	logic              take_a;
	logic              run_data;
	cff_pkg::cff_dstep_t step_a;
	cff_pkg::cff_dstep_t step_b;
	logic              fail_v;
	cff_pkg::cff_err_t fail_code;

	logic              v0, v1, v2;
	cff_pkg::cff_res_t c0;
	cff_pkg::cff_res_t slot0, slot1, slot2;
	logic [1:0]        n_res;
	logic              advance;
	logic              in_acc;
	logic              pop;
	cff_pkg::cff_res_t q_head;

	assign cur_phase = sof_s1 ? PH_HEADER : phase_q;
	assign cur_pos   = sof_s1 ? '0 : pos_q;
	assign cur_held  = sof_s1 ? '0 : held_q;
	assign cur_geom  = sof_s1 ? '0 : geom_q;
	assign cur_ctx   = sof_s1 ? '0 : ctx_q;
	assign nxt_pos   = (cur_pos != cff_pkg::POS_MAX) ? cur_pos + 16'd1 : cur_pos;

	assign act   = (cur_phase != PH_IDLE) && (cur_pos < file_length_q);
	assign magic = (cur_held == cff_pkg::PSF_MAGIC0) && (byte_s1 == cff_pkg::PSF_MAGIC_HI)
		&& (file_length_q >= cff_pkg::PSF_HDR);

	always_comb begin
		if (file_length_q == cff_pkg::CPI_LEN) begin
			bare_unit = cff_pkg::CPI_HEIGHT;
			bare_offset = cff_pkg::CPI_OFFSET;
			bare_size_bad = 1'b0;
		end else begin
			bare_unit = file_length_q[15:8];
			bare_offset = '0;
			bare_size_bad = (file_length_q[7:0] != 8'd0);
		end
		if (bare_size_bad) begin
			bare_err = cff_pkg::ERR_BARE_SIZE;
		end else if (bare_unit == 8'd0 || bare_unit > cff_pkg::MAX_ROWS_B) begin
			bare_err = cff_pkg::ERR_HEIGHT;
		end else begin
			bare_err = cff_pkg::ERR_NONE;
		end
		geom_bare.height = bare_unit[5:0];
		geom_bare.total = cff_pkg::GLYPHS_256;
		geom_bare.has_table = 1'b0;
		geom_bare.bm_start = bare_offset;
		geom_bare.bm_end = bare_offset + {bare_unit, 8'd0};
	end

	assign head = 17'(cff_pkg::PSF_HDR) + (cur_geom.total[9] ? {byte_s1, 9'd0}
		: {1'b0, byte_s1, 8'd0});

	assign take_a = act && (cur_phase == PH_HEADER) && (cur_pos != 16'd0) && !magic
		&& (bare_err == cff_pkg::ERR_NONE);
	assign run_data = act && (cur_phase == PH_DATA);

	assign step_a = cff_pkg::data_step(cur_ctx, geom_bare, file_length_q, 16'd0, cur_held);
	assign step_b = cff_pkg::data_step(take_a ? step_a.ctx : cur_ctx,
		take_a ? geom_bare : cur_geom, file_length_q, cur_pos, byte_s1);

	always_comb begin
		nxt_phase = cur_phase;
		nxt_held = cur_held;
		nxt_geom = cur_geom;
		nxt_ctx = cur_ctx;
		fail_v = 1'b0;
		fail_code = cff_pkg::ERR_NONE;
		if (act) begin
			unique case (cur_phase)
				PH_HEADER: begin
					if (cur_pos == 16'd0) begin
						if ({1'b0, file_length_q} > cff_pkg::MAX_FILE_B) begin
							fail_v = 1'b1;
							fail_code = cff_pkg::ERR_TOO_LARGE;
						end else if (file_length_q < 16'd2) begin
							fail_v = 1'b1;
							fail_code = bare_err;
						end else begin
							nxt_held = byte_s1;
						end
					end else if (magic) begin
						nxt_phase = PH_MODE;
					end else if (bare_err != cff_pkg::ERR_NONE) begin
						fail_v = 1'b1;
						fail_code = bare_err;
					end else begin
						nxt_geom = geom_bare;
						nxt_phase = PH_DATA;
					end
				end
				PH_MODE: begin
					if (byte_s1 > cff_pkg::MODE_MAX) begin
						fail_v = 1'b1;
						fail_code = cff_pkg::ERR_MODE;
					end else begin
						nxt_geom.total = ((byte_s1 & cff_pkg::MODE_512) != 8'd0)
							? cff_pkg::GLYPHS_512 : cff_pkg::GLYPHS_256;
						nxt_geom.has_table = ((byte_s1 & cff_pkg::MODE_TAB) != 8'd0);
						nxt_phase = PH_SIZE;
					end
				end
				PH_SIZE: begin
					if (head > {1'b0, file_length_q}
							|| (!cur_geom.has_table && head != {1'b0, file_length_q})) begin
						fail_v = 1'b1;
						fail_code = cff_pkg::ERR_PSF_LEN;
					end else if (byte_s1 == 8'd0 || byte_s1 > cff_pkg::MAX_ROWS_B) begin
						fail_v = 1'b1;
						fail_code = cff_pkg::ERR_HEIGHT;
					end else begin
						nxt_geom.height = byte_s1[5:0];
						nxt_geom.bm_start = cff_pkg::PSF_HDR;
						nxt_geom.bm_end = head[15:0];
						nxt_phase = PH_DATA;
					end
				end
				PH_DATA: begin
				end
				default: begin
				end
			endcase
		end
		if (fail_v) begin
			nxt_phase = PH_IDLE;
		end
		if (take_a || run_data) begin
			nxt_ctx = step_b.ctx;
			if (step_b.done_v) begin
				nxt_phase = PH_IDLE;
			end
		end
	end

	// pack results in order: error or first bare byte, then hit, then done
	assign v0 = fail_v || (take_a && step_a.hit_v);
	assign c0 = fail_v ? cff_pkg::err_res(fail_code) : step_a.hit;
	assign v1 = (take_a || run_data) && step_b.hit_v;
	assign v2 = (take_a || run_data) && step_b.done_v;
	assign n_res = {1'b0, v0} + {1'b0, v1} + {1'b0, v2};

	always_comb begin
		slot0 = v0 ? c0 : (v1 ? step_b.hit : step_b.done);
		slot1 = (v0 && v1) ? step_b.hit : step_b.done;
		slot2 = step_b.done;
		slot0.last = (n_res == 2'd1);
		slot1.last = (n_res == 2'd2);
		slot2.last = (n_res == 2'd3);
	end

	assign advance = valid_s1 && ({1'b0, count_q} + {2'b0, n_res} <= {1'b0, Q_DEPTH});
	assign s_axis_tready = !valid_s1 || advance;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign pop = m_axis_tvalid && m_axis_tready;

	assign q_head = q_mem_q[rd_ptr_q];
	assign m_axis_tvalid = (count_q != 3'd0);
	assign m_axis_tuser = q_head.kind;
	assign m_axis_tlast = q_head.last;
	assign m_axis_tdata = {1'b0, q_head.pairs_found, q_head.glyphs_found,
		q_head.height_found, q_head.error_code, q_head.code_point,
		q_head.bitmap_byte, q_head.row_index, q_head.glyph_index};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
			valid_s1 <= 1'b0;
			sof_s1 <= 1'b0;
			phase_q <= PH_HEADER;
			pos_q <= '0;
			held_q <= '0;
			geom_q <= '0;
			ctx_q <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (file_length_wr_en) begin
				file_length_q <= file_length_wr_data;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
				sof_s1 <= s_axis_tuser[0];
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q <= nxt_phase;
				pos_q <= nxt_pos;
				held_q <= nxt_held;
				geom_q <= nxt_geom;
				ctx_q <= nxt_ctx;
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (advance ? {1'b0, n_res} : 3'd0) - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance && n_res >= 2'd1) begin
			q_mem_q[wr_ptr_q] <= slot0;
		end
		if (advance && n_res >= 2'd2) begin
			q_mem_q[wr_ptr_q + 2'd1] <= slot1;
		end
		if (advance && n_res == 2'd3) begin
			q_mem_q[wr_ptr_q + 2'd2] <= slot2;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_DEPTH)
		else $error("result queue over capacity");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !sof_s1 && phase_q == PH_IDLE) |-> n_res == 2'd0)
		else $error("ended file produced a result");

	a_glyph_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> ctx_q.glyph_cnt <= geom_q.total)
		else $error("glyph counter ran past glyph total");

	a_table_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctx_q.table_glyph <= geom_q.total)
		else $error("table glyph ran past glyph total");

	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> count_q >= $past(count_q))
		else $error("queued result lost during stall");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: console font file parser
// Feeds font files one byte per item: short directed files for each error,
// header and table corner, then short random PSF, bare and noise files under
// changing file lengths. A parser model predicts every result, and each one
// is checked in order, field by field, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LIMIT = 2000000;
	localparam int SETTLE = 8;
	localparam int RANDOM_BYTES = 120;
	localparam int CALM_BYTES = 90;

	typedef enum logic [2:0] {ST_HEADER, ST_MODE, ST_SIZE, ST_DATA, ST_IDLE} parse_st_t;

	typedef struct packed {
		logic       sof;
		logic [7:0] data;
	} file_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        file_length_wr_en = 1'b0;
	logic [15:0] file_length_wr_data = '0;

	file_item_t          file_bytes_q[$];
	cff_pkg::cff_res_t   parsed_q[$];
	file_item_t cur;
	int         send_gap = 0;
	int         recv_gap = 0;
	bit         calm = 1'b0;
	int         cycles = 0;
	int         mismatches = 0;
	int         bytes_queued = 0;
	int         bytes_taken = 0;
	int         results_seen = 0;
	int         lengths_set = 0;
	int         kind_seen[4] = '{0, 0, 0, 0};

	// parser model state
	logic [15:0] len_reg = '0;
	int unsigned pos_cnt, bm_lo, bm_hi;
	parse_st_t   pstate;
	logic [15:0] hold_bytes;
	logic [5:0]  fnt_height;
	logic [9:0]  fnt_glyphs, glyph_at, tab_glyph;
	logic [4:0]  row_at;
	logic        tab_on, lo_pend;
	logic [7:0]  lo_byte;
	logic [13:0] pair_cnt;
	cff_pkg::cff_res_t step_res[3];
	int          step_n;

	console_font_file_parser_top u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.s_axis_tvalid       (s_axis_tvalid),
		.s_axis_tready       (s_axis_tready),
		.s_axis_tdata        (s_axis_tdata),
		.s_axis_tuser        (s_axis_tuser),
		.m_axis_tvalid       (m_axis_tvalid),
		.m_axis_tready       (m_axis_tready),
		.m_axis_tdata        (m_axis_tdata),
		.m_axis_tuser        (m_axis_tuser),
		.m_axis_tlast        (m_axis_tlast),
		.file_length_wr_en   (file_length_wr_en),
		.file_length_wr_data (file_length_wr_data)
	);

	always #4 clk = ~clk;

	function automatic void clear_font_state();
		pos_cnt = 0;
		pstate = ST_HEADER;
		hold_bytes = '0;
		fnt_height = '0;
		fnt_glyphs = '0;
		tab_on = 1'b0;
		glyph_at = '0;
		row_at = '0;
		lo_pend = 1'b0;
		lo_byte = '0;
		pair_cnt = '0;
		bm_lo = 0;
		bm_hi = 0;
		tab_glyph = '0;
	endfunction

	function automatic void add_result(cff_pkg::cff_kind_t k, logic [8:0] g, logic [4:0] r,
			logic [7:0] v, logic [15:0] cp, cff_pkg::cff_err_t e, logic [5:0] h,
			logic [9:0] gl, logic [13:0] pc);
		cff_pkg::cff_res_t x;
		x = '0;
		x.kind = k;
		x.glyph_index = g;
		x.row_index = r;
		x.bitmap_byte = v;
		x.code_point = cp;
		x.error_code = e;
		x.height_found = h;
		x.glyphs_found = gl;
		x.pairs_found = pc;
		step_res[step_n] = x;
		step_n++;
	endfunction

	function automatic void abort_file(cff_pkg::cff_err_t e);
		add_result(cff_pkg::KIND_ERROR, '0, '0, '0, '0, e, '0, '0, '0);
		pstate = ST_IDLE;
	endfunction

	function automatic cff_pkg::cff_err_t bare_geometry();
		int unsigned unit, offs;
		if (len_reg == cff_pkg::CPI_LEN) begin
			offs = cff_pkg::CPI_OFFSET;
			unit = cff_pkg::CPI_HEIGHT;
		end else begin
			if (len_reg[7:0] != 8'd0)
				return cff_pkg::ERR_BARE_SIZE;
			offs = 0;
			unit = len_reg >> 8;
		end
		if (unit < 1 || unit > cff_pkg::MAX_ROWS)
			return cff_pkg::ERR_HEIGHT;
		fnt_height = 6'(unit);
		fnt_glyphs = cff_pkg::GLYPHS_256;
		tab_on = 1'b0;
		bm_lo = offs;
		bm_hi = offs + 256 * unit;
		pstate = ST_DATA;
		return cff_pkg::ERR_NONE;
	endfunction

	function automatic void region_byte(int unsigned p, logic [7:0] b);
		logic [15:0] word;
		word = {b, lo_byte};
		if (p >= bm_lo && p < bm_hi) begin
			add_result(cff_pkg::KIND_GLYPH, glyph_at[8:0], row_at, b, '0, cff_pkg::ERR_NONE,
				'0, '0, '0);
			if (row_at + 1 >= fnt_height) begin
				row_at = '0;
				glyph_at++;
			end else begin
				row_at++;
			end
		end else if (tab_on && p >= bm_hi) begin
			if (!lo_pend) begin
				lo_pend = 1'b1;
				lo_byte = b;
			end else begin
				lo_pend = 1'b0;
				lo_byte = '0;
				if (tab_glyph < fnt_glyphs) begin
					if (word == cff_pkg::TABLE_SEP) begin
						tab_glyph++;
					end else begin
						add_result(cff_pkg::KIND_PAIR, tab_glyph[8:0], '0, '0, word,
							cff_pkg::ERR_NONE, '0, '0, '0);
						if (pair_cnt < cff_pkg::PAIR_MAX)
							pair_cnt++;
					end
				end
			end
		end
		if (p + 1 == len_reg) begin
			add_result(cff_pkg::KIND_DONE, '0, '0, '0, '0, cff_pkg::ERR_NONE, fnt_height,
				fnt_glyphs, pair_cnt);
			pstate = ST_IDLE;
		end
	endfunction

	function automatic void parse_byte(logic sof, logic [7:0] b);
		int unsigned p, head;
		cff_pkg::cff_err_t e;
		logic [7:0] b0;
		step_n = 0;
		if (sof)
			clear_font_state();
		p = pos_cnt;
		if (pos_cnt < cff_pkg::POS_MAX)
			pos_cnt++;
		if (pstate != ST_IDLE && p < len_reg) begin
			case (pstate)
				ST_HEADER: begin
					if (p == 0) begin
						if (len_reg > cff_pkg::MAX_FILE_BYTES) begin
							abort_file(cff_pkg::ERR_TOO_LARGE);
						end else if (len_reg < 2) begin
							e = bare_geometry();
							abort_file(e != cff_pkg::ERR_NONE ? e : cff_pkg::ERR_BARE_SIZE);
						end else begin
							hold_bytes = {8'h00, b};
						end
					end else begin
						b0 = hold_bytes[7:0];
						hold_bytes = {b, b0};
						if (b0 == cff_pkg::PSF_MAGIC0 && b == cff_pkg::PSF_MAGIC_HI
								&& len_reg >= cff_pkg::PSF_HDR) begin
							pstate = ST_MODE;
						end else begin
							e = bare_geometry();
							if (e != cff_pkg::ERR_NONE) begin
								abort_file(e);
							end else begin
								region_byte(0, b0);
								if (pstate == ST_DATA)
									region_byte(1, b);
							end
						end
					end
				end
				ST_MODE: begin
					if (b > cff_pkg::MODE_MAX) begin
						abort_file(cff_pkg::ERR_MODE);
					end else begin
						fnt_glyphs = ((b & cff_pkg::MODE_512) != 0) ? cff_pkg::GLYPHS_512
							: cff_pkg::GLYPHS_256;
						tab_on = ((b & cff_pkg::MODE_TAB) != 0);
						pstate = ST_SIZE;
					end
				end
				ST_SIZE: begin
					head = cff_pkg::PSF_HDR + fnt_glyphs * b;
					if (head > len_reg || (!tab_on && head != len_reg)) begin
						abort_file(cff_pkg::ERR_PSF_LEN);
					end else if (b < 1 || b > cff_pkg::MAX_ROWS) begin
						abort_file(cff_pkg::ERR_HEIGHT);
					end else begin
						fnt_height = b[5:0];
						bm_lo = cff_pkg::PSF_HDR;
						bm_hi = head;
						pstate = ST_DATA;
					end
				end
				default: region_byte(p, b);
			endcase
		end
		if (step_n > 0)
			step_res[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			parsed_q.push_back(step_res[i]);
	endfunction

	function automatic void check_result();
		cff_pkg::cff_res_t got, want;
		got = '0;
		got.kind = cff_pkg::cff_kind_t'(m_axis_tuser);
		got.glyph_index = m_axis_tdata[8:0];
		got.row_index = m_axis_tdata[13:9];
		got.bitmap_byte = m_axis_tdata[21:14];
		got.code_point = m_axis_tdata[37:22];
		got.error_code = cff_pkg::cff_err_t'(m_axis_tdata[40:38]);
		got.height_found = m_axis_tdata[46:41];
		got.glyphs_found = m_axis_tdata[56:47];
		got.pairs_found = m_axis_tdata[70:57];
		got.last = m_axis_tlast;
		results_seen++;
		if (!$isunknown(m_axis_tuser))
			kind_seen[m_axis_tuser]++;
		if (parsed_q.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result %0d: kind %0d tdata %h", results_seen,
					m_axis_tuser, m_axis_tdata);
			mismatches++;
			return;
		end
		want = parsed_q.pop_front();
		if (got.kind !== want.kind || got.glyph_index !== want.glyph_index ||
				got.row_index !== want.row_index || got.bitmap_byte !== want.bitmap_byte ||
				got.code_point !== want.code_point || got.error_code !== want.error_code ||
				got.height_found !== want.height_found ||
				got.glyphs_found !== want.glyphs_found ||
				got.pairs_found !== want.pairs_found || got.last !== want.last) begin
			if (mismatches < 10) begin
				$display("result %0d exp/got: kind %0d/%0d glyph %0d/%0d row %0d/%0d",
					results_seen, want.kind, got.kind, want.glyph_index,
					got.glyph_index, want.row_index, got.row_index);
				$display("  byte %h/%h cp %h/%h err %0d/%0d h %0d/%0d",
					want.bitmap_byte, got.bitmap_byte, want.code_point, got.code_point,
					want.error_code, got.error_code, want.height_found,
					got.height_found);
				$display("  g %0d/%0d p %0d/%0d last %0b/%0b", want.glyphs_found,
					got.glyphs_found, want.pairs_found, got.pairs_found,
					want.last, got.last);
			end
			mismatches++;
		end
	endfunction

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				parse_byte(s_axis_tuser[0], s_axis_tdata);
				bytes_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (file_bytes_q.size() > 0) begin
					cur = file_bytes_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= cur.data;
					s_axis_tuser <= cur.sof;
					if (!calm && $urandom_range(0, 9) == 0)
						send_gap = $urandom_range(1, 7);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0)
					recv_gap = $urandom_range(1, 7);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				parsed_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic push_byte(logic sof, logic [7:0] b);
		file_bytes_q.push_back({sof, b});
		bytes_queued++;
	endtask

	task automatic wait_idle();
		while (file_bytes_q.size() != 0 || s_axis_tvalid || parsed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_length(logic [15:0] v);
		wait_idle();
		file_length_wr_en <= 1'b1;
		file_length_wr_data <= v;
		@(posedge clk);
		file_length_wr_en <= 1'b0;
		len_reg = v;
		lengths_set++;
	endtask

	task automatic queue_psf(logic [7:0] mode, logic [7:0] rows, int unsigned cut,
			int unsigned sep_pct);
		int unsigned head;
		logic [15:0] w;
		head = cff_pkg::PSF_HDR + (((mode & cff_pkg::MODE_512) != 0)
			? cff_pkg::GLYPHS_512 : cff_pkg::GLYPHS_256) * rows;
		w = '0;
		for (int unsigned k = 0; k < cut; k++) begin
			if (k == 0) begin
				push_byte(1'b1, cff_pkg::PSF_MAGIC0);
			end else if (k == 1) begin
				push_byte(1'b0, cff_pkg::PSF_MAGIC_HI);
			end else if (k == 2) begin
				push_byte(1'b0, mode);
			end else if (k == 3) begin
				push_byte(1'b0, rows);
			end else if (k < head) begin
				push_byte(1'b0, 8'($urandom));
			end else if (((k - head) & 1) == 0) begin
				w = ($urandom_range(1, 100) <= sep_pct) ? cff_pkg::TABLE_SEP : 16'($urandom);
				push_byte(1'b0, w[7:0]);
			end else begin
				push_byte(1'b0, w[15:8]);
			end
		end
	endtask

	task automatic queue_bare(logic [7:0] b0, logic [7:0] b1, int unsigned cut);
		for (int unsigned k = 0; k < cut; k++) begin
			if (k == 0)
				push_byte(1'b1, b0);
			else if (k == 1)
				push_byte(1'b0, b1);
			else
				push_byte(1'b0, 8'($urandom));
		end
	endtask

	task automatic queue_noise(int unsigned n);
		for (int unsigned k = 0; k < n; k++)
			push_byte(k == 0 || $urandom_range(0, 30) == 0, 8'($urandom));
	endtask

	initial begin
		int rand_base, pick, variant;
		int unsigned flen, head, glyphs;
		logic [7:0] mode, rows;
		clear_font_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// header errors and length corners
		set_length(16'd0);
		queue_noise(3);
		set_length(16'd1);
		queue_noise(2);
		set_length(16'hFFFF);
		queue_noise(2);
		set_length(16'(cff_pkg::MAX_FILE_BYTES + 1));
		queue_noise(2);
		set_length(16'd300);
		queue_bare(8'h00, 8'hFF, 3);
		set_length(16'd3);
		queue_bare(cff_pkg::PSF_MAGIC0, cff_pkg::PSF_MAGIC_HI, 4);
		set_length(16'd8448);
		queue_bare(8'h12, 8'h34, 2);
		set_length(16'd260);
		queue_psf(8'h04, 8'd1, 4, 0);
		queue_psf(8'hFF, 8'd1, 4, 0);
		queue_psf(8'h00, 8'd2, 4, 0);
		queue_psf(cff_pkg::MODE_TAB, 8'd0, 5, 0);
		set_length(16'd9000);
		queue_psf(cff_pkg::MODE_MAX, 8'd32, 6, 0);
		queue_psf(cff_pkg::MODE_TAB, 8'd33, 6, 0);

		// the held first bytes, tall glyphs and the three code page layout
		set_length(16'd256);
		queue_bare(cff_pkg::PSF_MAGIC0, cff_pkg::PSF_MAGIC_HI, 4);
		set_length(16'd32768);
		queue_bare(8'hA5, 8'h5A, 2);
		queue_psf(cff_pkg::MODE_MAX, 8'd32, 12, 0);
		set_length(cff_pkg::CPI_LEN);
		queue_bare(8'h00, 8'h00, 48);

		// full file with a unicode table and an odd trailing byte
		set_length(16'd281);
		queue_psf(cff_pkg::MODE_TAB, 8'd1, 281, 40);

		rand_base = bytes_queued;
		while (bytes_queued - rand_base < RANDOM_BYTES) begin
			if (bytes_queued - rand_base >= CALM_BYTES)
				calm = 1'b1;
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				mode = 8'($urandom_range(0, 3));
				rows = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(2, 3)) : 8'd1;
				glyphs = ((mode & cff_pkg::MODE_512) != 0) ? cff_pkg::GLYPHS_512
					: cff_pkg::GLYPHS_256;
				head = cff_pkg::PSF_HDR + glyphs * rows;
				flen = head + (((mode & cff_pkg::MODE_TAB) != 0) ? $urandom_range(0, 160) : 0);
				set_length(16'(flen));
				variant = $urandom_range(0, 2);
				if (variant == 0)
					queue_psf(8'($urandom), 8'($urandom_range(0, 40)),
						$urandom_range(2, 8), 30);
				else
					queue_psf(mode, rows, $urandom_range(1, 24), 20);
			end else if (pick < 8) begin
				flen = 256 * $urandom_range(1, 2);
				set_length(16'(flen));
				queue_bare(8'($urandom), 8'($urandom), $urandom_range(1, 24));
			end else begin
				set_length(($urandom_range(0, 1) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 600)));
				queue_noise($urandom_range(1, 24));
			end
		end

		wait_idle();
		$display("run covered %0d file bytes under %0d file lengths, %0d results checked",
			bytes_taken, lengths_set, results_seen);
		$display("glyph bytes %0d, unicode pairs %0d, errors %0d, done summaries %0d",
			kind_seen[cff_pkg::KIND_GLYPH], kind_seen[cff_pkg::KIND_PAIR],
			kind_seen[cff_pkg::KIND_ERROR], kind_seen[cff_pkg::KIND_DONE]);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
design/cff_pkg.sv
design/console_font_file_parser_top.sv
sim/testbench.sv
